### rtl/rtti_pkg.sv
// ----------------------------------------------------------------------------
// Radix text-to-integer package
// Shared widths, parse phases, status codes and character classes.
// ----------------------------------------------------------------------------
package rtti_pkg;

  localparam int unsigned ValueBits   = 64;
  localparam int unsigned CountBits   = 16;
  localparam int unsigned CharBits    = 8;
  localparam int unsigned BaseBits    = 6;
  localparam int unsigned DigitBits   = 6;
  localparam int unsigned StatusBits  = 2;
  localparam int unsigned OutDataBits = 88;
  localparam int unsigned OutPadBits  = OutDataBits - ValueBits - CountBits - StatusBits;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrBits    = $clog2(QueueDepth);
  localparam int unsigned QCntBits    = $clog2(QueueDepth + 1);

  localparam logic RegNumberBase = 1'b0;
  localparam logic RegSignedMode = 1'b1;

  localparam logic [BaseBits-1:0] BaseAuto  = BaseBits'(0);
  localparam logic [BaseBits-1:0] BaseOct   = BaseBits'(8);
  localparam logic [BaseBits-1:0] BaseDec   = BaseBits'(10);
  localparam logic [BaseBits-1:0] BaseHex   = BaseBits'(16);
  localparam logic [BaseBits-1:0] BaseMin   = BaseBits'(2);
  localparam logic [BaseBits-1:0] BaseMax   = BaseBits'(36);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_ZERO_X,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK,
    ST_NO_DIGITS,
    ST_RANGE,
    ST_BAD_BASE
  } status_e;

  typedef struct packed {
    logic                 is_nul;
    logic                 is_space;
    logic                 is_sign;
    logic                 is_minus;
    logic                 is_x;
    logic                 is_zero;
    logic                 digit_ok;
    logic [DigitBits-1:0] digit;
  } char_class_t;

endpackage

### rtl/rtti_front.sv
// ----------------------------------------------------------------------------
// Radix text-to-integer front end
// Accepts text bytes, classifies each one and holds it in an output register.
// ----------------------------------------------------------------------------
module rtti_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [rtti_pkg::CharBits-1:0]    char_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output rtti_pkg::char_class_t            class_o
);

  logic                  valid_q, valid_d;
  rtti_pkg::char_class_t class_q, class_d;
  logic                  load;

  always_comb begin
    class_d          = '0;
    class_d.is_nul   = (char_i == 8'h00);
    class_d.is_space = (char_i == 8'h20) || (char_i >= 8'h09 && char_i <= 8'h0D);
    class_d.is_sign  = (char_i == 8'h2B) || (char_i == 8'h2D);
    class_d.is_minus = (char_i == 8'h2D);
    class_d.is_x     = (char_i == 8'h78) || (char_i == 8'h58);
    class_d.is_zero  = (char_i == 8'h30);
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      class_d.digit_ok = 1'b1;
      class_d.digit    = rtti_pkg::DigitBits'(char_i - 8'h30);
    end else if (char_i >= 8'h61 && char_i <= 8'h7A) begin
      class_d.digit_ok = 1'b1;
      class_d.digit    = rtti_pkg::DigitBits'(char_i - 8'h57);
    end else if (char_i >= 8'h41 && char_i <= 8'h5A) begin
      class_d.digit_ok = 1'b1;
      class_d.digit    = rtti_pkg::DigitBits'(char_i - 8'h37);
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      class_q <= class_d;
    end
  end

  assign valid_o = valid_q;
  assign class_o = class_q;

endmodule

### rtl/rtti_queue.sv
// ----------------------------------------------------------------------------
// Radix text-to-integer queue
// Short first-in first-out buffer of classified characters.
// ----------------------------------------------------------------------------
module rtti_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  rtti_pkg::char_class_t class_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output rtti_pkg::char_class_t class_o
);

  rtti_pkg::char_class_t            mem_q [rtti_pkg::QueueDepth];
  logic [rtti_pkg::QPtrBits-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rtti_pkg::QCntBits-1:0]    count_q, count_d;
  logic                             push, pop;

  localparam logic [rtti_pkg::QPtrBits-1:0] PtrLast = rtti_pkg::QPtrBits'(rtti_pkg::QueueDepth - 1);
  localparam logic [rtti_pkg::QCntBits-1:0] CntFull = rtti_pkg::QCntBits'(rtti_pkg::QueueDepth);

  assign ready_o = (count_q != CntFull);
  assign valid_o = (count_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign class_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= class_i;
    end
  end

endmodule

### rtl/rtti_back.sv
// ----------------------------------------------------------------------------
// Radix text-to-integer back end
// Runs the parse phases, accumulates digits and registers the final result.
// ----------------------------------------------------------------------------
module rtti_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [rtti_pkg::BaseBits-1:0]     number_base_i,
  input  logic                              signed_mode_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  rtti_pkg::char_class_t             class_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [rtti_pkg::ValueBits-1:0]    value_o,
  output logic [rtti_pkg::CountBits-1:0]    end_position_o,
  output rtti_pkg::status_e                 status_o
);

  localparam int unsigned ProdBits = rtti_pkg::ValueBits + rtti_pkg::BaseBits;
  localparam logic [rtti_pkg::ValueBits-1:0] SMin = {1'b1, {(rtti_pkg::ValueBits-1){1'b0}}};
  localparam logic [rtti_pkg::CountBits-1:0] PosMax = '1;

  rtti_pkg::phase_e                  phase_q, phase_d, first_next;
  logic                              neg_q, neg_d;
  logic [rtti_pkg::BaseBits-1:0]     base_q, base_d;
  logic [rtti_pkg::ValueBits-1:0]    acc_q, acc_d;
  logic                              ovf_q, ovf_d;
  logic                              seen_q, seen_d;
  logic [rtti_pkg::CountBits-1:0]    pos_q, pos_d, stop_q, stop_d, next_pos;

  logic                              out_valid_q, out_valid_d;
  logic [rtti_pkg::ValueBits-1:0]    value_q, value_d;
  logic [rtti_pkg::CountBits-1:0]    endp_q, endp_d;
  rtti_pkg::status_e                 status_q, status_d;

  logic                              pop, take_char, take_nul;
  logic                              base_ok, first, first_zero, take_sign, try_step, digit_hit;
  logic [rtti_pkg::BaseBits-1:0]     step_base;
  logic [ProdBits-1:0]               prod;
  logic [rtti_pkg::ValueBits-1:0]    neg_acc;

  assign ready_o   = !class_i.is_nul || !out_valid_q || ready_i;
  assign pop       = valid_i && ready_o;
  assign take_char = pop && !class_i.is_nul;
  assign take_nul  = pop && class_i.is_nul;

  assign base_ok    = (number_base_i == rtti_pkg::BaseAuto) ||
                      (number_base_i >= rtti_pkg::BaseMin && number_base_i <= rtti_pkg::BaseMax);
  assign first      = (phase_q == rtti_pkg::PH_SPACE && !class_i.is_space && !class_i.is_sign) ||
                      (phase_q == rtti_pkg::PH_SIGN);
  assign take_sign  = (phase_q == rtti_pkg::PH_SPACE) && !class_i.is_space && class_i.is_sign;
  assign first_zero = first && base_ok && class_i.is_zero &&
                      (number_base_i == rtti_pkg::BaseAuto || number_base_i == rtti_pkg::BaseHex);
  assign next_pos   = (pos_q == PosMax) ? PosMax : pos_q + 1'b1;

  always_comb begin
    priority if (first) begin
      step_base = (number_base_i == rtti_pkg::BaseAuto) ? rtti_pkg::BaseDec : number_base_i;
    end else if (phase_q == rtti_pkg::PH_ZERO_X) begin
      step_base = rtti_pkg::BaseHex;
    end else begin
      step_base = base_q;
    end
  end

  assign try_step  = (first && base_ok && !first_zero) ||
                     (phase_q == rtti_pkg::PH_ZERO && !class_i.is_x) ||
                     (phase_q == rtti_pkg::PH_ZERO_X) ||
                     (phase_q == rtti_pkg::PH_DIGITS);
  assign digit_hit = try_step && class_i.digit_ok &&
                     (rtti_pkg::BaseBits'(class_i.digit) < step_base);
  assign prod      = ProdBits'(acc_q) * ProdBits'(step_base) + ProdBits'(class_i.digit);
  assign neg_acc   = '0 - acc_q;

  always_comb begin
    priority if (!base_ok) begin
      first_next = rtti_pkg::PH_DONE;
    end else if (first_zero) begin
      first_next = rtti_pkg::PH_ZERO;
    end else if (digit_hit) begin
      first_next = rtti_pkg::PH_DIGITS;
    end else begin
      first_next = rtti_pkg::PH_DONE;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (take_nul) begin
      phase_d = rtti_pkg::PH_SPACE;
    end else if (take_char) begin
      unique case (phase_q)
        rtti_pkg::PH_SPACE: begin
          if (class_i.is_space) begin
            phase_d = rtti_pkg::PH_SPACE;
          end else if (class_i.is_sign) begin
            phase_d = rtti_pkg::PH_SIGN;
          end else begin
            phase_d = first_next;
          end
        end
        rtti_pkg::PH_SIGN: begin
          phase_d = first_next;
        end
        rtti_pkg::PH_ZERO: begin
          if (class_i.is_x) begin
            phase_d = rtti_pkg::PH_ZERO_X;
          end else begin
            phase_d = digit_hit ? rtti_pkg::PH_DIGITS : rtti_pkg::PH_DONE;
          end
        end
        rtti_pkg::PH_ZERO_X, rtti_pkg::PH_DIGITS: begin
          phase_d = digit_hit ? rtti_pkg::PH_DIGITS : rtti_pkg::PH_DONE;
        end
        rtti_pkg::PH_DONE: begin
          phase_d = rtti_pkg::PH_DONE;
        end
        default: begin
          phase_d = rtti_pkg::PH_DONE;
        end
      endcase
    end
  end

  always_comb begin
    neg_d  = neg_q;
    base_d = base_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    seen_d = seen_q;
    pos_d  = pos_q;
    stop_d = stop_q;
    if (take_nul) begin
      neg_d  = 1'b0;
      base_d = '0;
      acc_d  = '0;
      ovf_d  = 1'b0;
      seen_d = 1'b0;
      pos_d  = '0;
      stop_d = '0;
    end else if (take_char) begin
      pos_d = next_pos;
      if (take_sign) begin
        neg_d = class_i.is_minus;
      end
      if (first && base_ok) begin
        if (first_zero) begin
          base_d = (number_base_i == rtti_pkg::BaseAuto) ? rtti_pkg::BaseOct : rtti_pkg::BaseHex;
        end else begin
          base_d = step_base;
        end
      end
      if (first_zero) begin
        seen_d = 1'b1;
        stop_d = next_pos;
      end
      if (digit_hit) begin
        base_d = step_base;
        acc_d  = prod[rtti_pkg::ValueBits-1:0];
        ovf_d  = ovf_q || (|prod[ProdBits-1:rtti_pkg::ValueBits]);
        seen_d = 1'b1;
        stop_d = next_pos;
      end
    end
  end

  always_comb begin
    value_d  = '0;
    endp_d   = stop_q;
    status_d = rtti_pkg::ST_OK;
    priority if (!base_ok) begin
      endp_d   = '0;
      status_d = rtti_pkg::ST_BAD_BASE;
    end else if (!seen_q) begin
      endp_d   = '0;
      status_d = rtti_pkg::ST_NO_DIGITS;
    end else if (!signed_mode_i) begin
      if (ovf_q) begin
        value_d  = '1;
        status_d = rtti_pkg::ST_RANGE;
      end else begin
        value_d = neg_q ? neg_acc : acc_q;
      end
    end else if (ovf_q || acc_q[rtti_pkg::ValueBits-1]) begin
      if (neg_q && !ovf_q && acc_q == SMin) begin
        value_d = SMin;
      end else begin
        value_d  = neg_q ? SMin : SMin - 1'b1;
        status_d = rtti_pkg::ST_RANGE;
      end
    end else begin
      value_d = neg_q ? neg_acc : acc_q;
    end
  end

  assign out_valid_d = take_nul || (out_valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rtti_pkg::PH_SPACE;
      neg_q       <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      seen_q      <= 1'b0;
      pos_q       <= '0;
      stop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      base_q      <= base_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_nul) begin
      value_q  <= value_d;
      endp_q   <= endp_d;
      status_q <= status_d;
    end
  end

  assign valid_o        = out_valid_q;
  assign value_o        = value_q;
  assign end_position_o = endp_q;
  assign status_o       = status_q;

endmodule

### rtl/radix_text_to_integer_unit.sv
// ----------------------------------------------------------------------------
// Radix text-to-integer unit
// Streams NUL-terminated text and returns the converted integer on the NUL.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, except that a NUL waits while an earlier result is held by the receiver.
// After the terminating NUL transfer it passes the classify register, the queue
//   and the accumulator step with result register before the result is valid.
// The digit step is one 64 x 6 multiply-add per cycle in the back end.
// Reset: asynchronous, active low; clears parse state, queue pointers, valid flags and configuration registers.
module radix_text_to_integer_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [rtti_pkg::CharBits-1:0]         s_axis_tdata,  // [7:0] character
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [rtti_pkg::OutDataBits-1:0]      m_axis_tdata,  // [63:0] value,
                                                               // [79:64] end_position,
                                                               // [81:80] status
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  cfg_index_i,
  input  logic [rtti_pkg::BaseBits-1:0]         cfg_data_i
);

  logic [rtti_pkg::BaseBits-1:0]   number_base_q, number_base_d;
  logic                            signed_mode_q, signed_mode_d;

  logic                            fr_valid, fr_ready, q_valid, q_ready;
  rtti_pkg::char_class_t           fr_class, q_class;
  logic [rtti_pkg::ValueBits-1:0]  value;
  logic [rtti_pkg::CountBits-1:0]  end_position;
  rtti_pkg::status_e               status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    number_base_d = number_base_q;
    signed_mode_d = signed_mode_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == rtti_pkg::RegSignedMode) begin
        signed_mode_d = cfg_data_i[0];
      end else begin
        number_base_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= '0;
      signed_mode_q <= 1'b0;
    end else begin
      number_base_q <= number_base_d;
      signed_mode_q <= signed_mode_d;
    end
  end

  rtti_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .char_i  (s_axis_tdata),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .class_o (fr_class)
  );

  rtti_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .class_i (fr_class),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .class_o (q_class)
  );

  rtti_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .number_base_i  (number_base_q),
    .signed_mode_i  (signed_mode_q),
    .valid_i        (q_valid),
    .ready_o        (q_ready),
    .class_i        (q_class),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .value_o        (value),
    .end_position_o (end_position),
    .status_o       (status)
  );

  assign m_axis_tdata = {{rtti_pkg::OutPadBits{1'b0}}, status, end_position, value};

  a_bad_base_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == rtti_pkg::ST_BAD_BASE) |-> (value == '0 && end_position == '0))
    else $error("invalid base result not cleared");

  a_no_digits_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status == rtti_pkg::ST_NO_DIGITS) |-> (value == '0 && end_position == '0))
    else $error("no-digit result not cleared");

  a_ok_has_position : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (status == rtti_pkg::ST_OK || status == rtti_pkg::ST_RANGE))
      |-> (end_position != '0))
    else $error("converted result without end position");

endmodule

### test/radix_text_to_integer_unit_test.sv
// ----------------------------------------------------------------------------
// Radix text-to-integer unit testbench
// Streams NUL-terminated texts through the unit, predicts every conversion
// with a behavioural parser kept in step with the accepted characters, and
// compares value, end position and status of each returned result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module radix_text_to_integer_unit_test;
  import rtti_pkg::*;

  localparam int unsigned ClockPeriod = 12;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned RandomChars = 600;
  localparam int unsigned LongZeros   = 40;

  localparam logic [CharBits-1:0]  CharNul  = 8'h00;
  localparam logic [7:0]           NoDigit  = 8'hff;
  localparam logic [ValueBits-1:0] AllOnes  = {ValueBits{1'b1}};
  localparam logic [ValueBits-1:0] SignMin  = {1'b1, {(ValueBits - 1){1'b0}}};
  localparam logic [CountBits-1:0] PosLimit = {CountBits{1'b1}};

  localparam int unsigned EndLsb    = ValueBits;
  localparam int unsigned StatusLsb = ValueBits + CountBits;

  localparam logic [7:0] StallPattern = 8'b1011_0110;

  typedef struct {
    logic [ValueBits-1:0] value;
    logic [CountBits-1:0] end_position;
    status_e              status;
  } conversion_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [CharBits-1:0]    s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic                   cfg_index_i   = 1'b0;
  logic [BaseBits-1:0]    cfg_data_i    = '0;

  radix_text_to_integer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClockPeriod / 2) clk_i = ~clk_i;

  // Shadow registers and parse state of the current text
  logic [BaseBits-1:0]  cfg_base   = BaseAuto;
  logic                 cfg_signed = 1'b0;
  phase_e               run_phase  = PH_SPACE;
  logic                 run_negative;
  logic [BaseBits-1:0]  run_radix;
  logic [ValueBits-1:0] run_acc;
  logic                 run_overflow;
  logic                 run_has_digit;
  logic [CountBits-1:0] run_pos;
  logic [CountBits-1:0] run_stop;

  conversion_t   awaited_conversions[$];
  conversion_t   oldest_conversion;
  logic [7:0]    text_q[$];
  int unsigned   error_count     = 0;
  int unsigned   chars_sent      = 0;
  int unsigned   burst_left      = 0;
  bit            sender_steady   = 1'b0;
  int unsigned   holds_requested = 0;
  int unsigned   holds_served    = 0;
  int unsigned   hold_left       = 0;
  int unsigned   ready_mode      = 0;
  int unsigned   ready_cycle     = 0;

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 8'd10;
    if (c >= "A" && c <= "Z") return c - "A" + 8'd10;
    return NoDigit;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit radix_invalid(input logic [BaseBits-1:0] b);
    return b == 6'd1 || b > BaseMax;
  endfunction

  function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] p);
    return (p == PosLimit) ? p : p + 1'b1;
  endfunction

  task automatic clear_run();
    run_phase     = PH_SPACE;
    run_negative  = 1'b0;
    run_radix     = '0;
    run_acc       = '0;
    run_overflow  = 1'b0;
    run_has_digit = 1'b0;
    run_pos       = '0;
    run_stop      = '0;
  endtask

  task automatic take_digit(input logic [7:0] c);
    logic [7:0] d;
    d = digit_value(c);
    if (run_radix >= BaseMin && d < run_radix) begin
      if (run_acc > (AllOnes - d) / run_radix) run_overflow = 1'b1;
      run_acc       = run_acc * run_radix + d;
      run_has_digit = 1'b1;
      run_stop      = bump(run_pos);
      run_phase     = PH_DIGITS;
    end else begin
      run_phase = PH_DONE;
    end
  endtask

  task automatic begin_number(input logic [7:0] c);
    if (radix_invalid(cfg_base)) begin
      run_phase = PH_DONE;
    end else if ((cfg_base == BaseAuto || cfg_base == BaseHex) && c == "0") begin
      run_radix     = (cfg_base == BaseAuto) ? BaseOct : BaseHex;
      run_acc       = '0;
      run_has_digit = 1'b1;
      run_stop      = bump(run_pos);
      run_phase     = PH_ZERO;
    end else begin
      run_radix = (cfg_base == BaseAuto) ? BaseDec : cfg_base;
      take_digit(c);
    end
  endtask

  task automatic convert_char(input logic [7:0] c);
    conversion_t r;
    if (c != CharNul) begin
      case (run_phase)
        PH_SPACE: begin
          if (!is_blank(c)) begin
            if (c == "-" || c == "+") begin
              run_negative = (c == "-");
              run_phase    = PH_SIGN;
            end else begin
              begin_number(c);
            end
          end
        end
        PH_SIGN: begin_number(c);
        PH_ZERO: begin
          if (c == "x" || c == "X") run_phase = PH_ZERO_X;
          else take_digit(c);
        end
        PH_ZERO_X: begin
          if (digit_value(c) < 8'd16) begin
            run_radix = BaseHex;
            take_digit(c);
          end else begin
            run_phase = PH_DONE;
          end
        end
        PH_DIGITS: take_digit(c);
        default: ;
      endcase
      run_pos = bump(run_pos);
    end else begin
      r.end_position = run_stop;
      r.status       = ST_OK;
      if (radix_invalid(cfg_base)) begin
        r.value = '0; r.end_position = '0; r.status = ST_BAD_BASE;
      end else if (!run_has_digit) begin
        r.value = '0; r.end_position = '0; r.status = ST_NO_DIGITS;
      end else if (!cfg_signed) begin
        if (run_overflow) begin
          r.value = AllOnes; r.status = ST_RANGE;
        end else begin
          r.value = run_negative ? -run_acc : run_acc;
        end
      end else if (run_overflow || run_acc >= SignMin) begin
        if (run_negative && !run_overflow && run_acc == SignMin) begin
          r.value = SignMin;
        end else begin
          r.value  = run_negative ? SignMin : SignMin - 1'b1;
          r.status = ST_RANGE;
        end
      end else begin
        r.value = run_negative ? -run_acc : run_acc;
      end
      awaited_conversions.push_back(r);
      clear_run();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_conversions.size() == 0) begin
        $error("unexpected result: value %h", m_axis_tdata[0 +: ValueBits]);
        error_count++;
      end else begin
        oldest_conversion = awaited_conversions.pop_front();
        if (m_axis_tdata[0 +: ValueBits] !== oldest_conversion.value) begin
          $error("value mismatch: expected %h, actual %h",
                 oldest_conversion.value, m_axis_tdata[0 +: ValueBits]);
          error_count++;
        end
        if (m_axis_tdata[EndLsb +: CountBits] !== oldest_conversion.end_position) begin
          $error("end_position mismatch: expected %0d, actual %0d",
                 oldest_conversion.end_position, m_axis_tdata[EndLsb +: CountBits]);
          error_count++;
        end
        if (m_axis_tdata[StatusLsb +: StatusBits] !== oldest_conversion.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest_conversion.status, m_axis_tdata[StatusLsb +: StatusBits]);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: changing stall patterns, with long hold-offs on request
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ready_cycle <= ready_cycle + 1;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      holds_served  <= holds_served + 1;
    end else begin
      if (ready_cycle % 97 == 0) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= StallPattern[ready_cycle % 8];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    gap = 0;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    convert_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CharNul);
  endtask

  task automatic send_text_q();
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(CharNul);
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_conversions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [BaseBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == RegNumberBase) cfg_base = data;
    else cfg_signed = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [BaseBits-1:0] base, input logic sgn);
    drain();
    write_reg(RegNumberBase, base);
    write_reg(RegSignedMode, {5'($urandom_range(0, 31)), sgn});
  endtask

  // --------------------------------------------------------------------------
  // Random text generation
  // --------------------------------------------------------------------------
  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) != 0) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned v;
    v = $urandom_range(8, 13);
    return (v == 8) ? 8'd32 : 8'(v);
  endfunction

  task automatic build_random_text();
    int unsigned kind;
    int unsigned radix;
    int unsigned ndig;
    int unsigned r;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) text_q.push_back(blank_char());
      r = $urandom_range(0, 3);
      if (r == 0) text_q.push_back("-");
      else if (r == 1) text_q.push_back("+");
      radix = (radix_invalid(cfg_base) || cfg_base == BaseAuto) ? 10 : cfg_base;
      r = $urandom_range(0, 5);
      if (r == 0) begin
        text_q.push_back("0");
        if (cfg_base == BaseAuto) radix = 8;
      end else if (r == 1) begin
        text_q.push_back("0");
        text_q.push_back(($urandom_range(0, 1) != 0) ? "x" : "X");
        if (cfg_base == BaseAuto || cfg_base == BaseHex) radix = 16;
      end
      r = $urandom_range(0, 9);
      if (r < 7) ndig = $urandom_range(1, 12);
      else if (r < 9) ndig = $urandom_range(13, 22);
      else ndig = $urandom_range(23, 70);
      repeat (ndig) text_q.push_back(digit_char($urandom_range(0, radix - 1)));
      if (kind == 9) begin
        repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(1, 255)));
      end
    end
  endtask

  function automatic logic [BaseBits-1:0] random_base();
    case ($urandom_range(0, 9))
      0, 1:    return BaseAuto;
      2:       return BaseDec;
      3:       return BaseHex;
      4:       return BaseOct;
      5:       return BaseMin;
      6:       return BaseMax;
      default: return BaseBits'($urandom_range(0, 63));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_config();
    send_text(" \t-0x1F");
    send_text("42");
  endtask

  task automatic test_prefix_rules();
    set_config(BaseAuto, 1'b0);
    send_text("0x");
    send_text("0xg");
    send_text("0X1a");
    send_text("017");
    send_text("089");
    send_text("0");
    set_config(BaseHex, 1'b0);
    send_text("0x10");
    send_text("0xz");
    send_text("ff");
  endtask

  task automatic test_signs_and_blanks();
    set_config(BaseDec, 1'b0);
    send_text("--5");
    send_text("- 5");
    send_text("+7");
    send_text("-5");
    send_text("\013\014\015\n 9");
  endtask

  task automatic test_no_digits();
    send_text("");
    send_text("   ");
    send_text("+");
    send_text("xyz");
  endtask

  task automatic test_radix_extremes();
    set_config(BaseMin, 1'b0);
    send_text("1012");
    set_config(BaseMax, 1'b1);
    send_text("zZ9");
    set_config(6'd35, 1'b0);
    send_text("z");
  endtask

  task automatic test_unsigned_range();
    set_config(BaseDec, 1'b0);
    send_text("18446744073709551615");
    send_text("18446744073709551616");
    send_text("-18446744073709551616");
    send_text("-1");
  endtask

  task automatic test_signed_range();
    set_config(BaseDec, 1'b1);
    send_text("9223372036854775807");
    send_text("9223372036854775808");
    send_text("-9223372036854775808");
    send_text("-9223372036854775809");
    send_text("-99999999999999999999999");
  endtask

  task automatic test_invalid_base();
    set_config(6'd1, 1'b0);
    send_text("123");
    set_config(6'd37, 1'b1);
    send_text("5");
    set_config(6'd63, 1'b0);
    send_text("");
  endtask

  task automatic test_ignored_tail();
    set_config(BaseAuto, 1'b0);
    send_text("12abc\377\200  -9");
  endtask

  task automatic test_long_text();
    set_config(BaseDec, 1'b0);
    sender_steady = 1'b1;
    repeat (LongZeros) send_char("0");
    send_char("7");
    send_char(CharNul);
    sender_steady = 1'b0;
  endtask

  task automatic test_output_backpressure();
    set_config(BaseDec, 1'b1);
    holds_requested++;
    sender_steady = 1'b1;
    repeat (12) begin
      send_text("7");
      send_text("-3");
    end
    sender_steady = 1'b0;
  endtask

  task automatic test_random_texts();
    int unsigned stop_at;
    stop_at = chars_sent + RandomChars;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) set_config(random_base(), $urandom_range(0, 1));
      sender_steady = ($urandom_range(0, 15) == 0);
      build_random_text();
      send_text_q();
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    clear_run();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_prefix_rules();
    test_signs_and_blanks();
    test_no_digits();
    test_radix_extremes();
    test_unsigned_range();
    test_signed_range();
    test_invalid_base();
    test_ignored_tail();
    test_long_text();
    test_output_backpressure();
    test_random_texts();

    s_axis_tvalid <= 1'b0;
    for (int i = 0; i < 4000 && awaited_conversions.size() != 0; i++) @(posedge clk_i);
    if (awaited_conversions.size() != 0) begin
      $error("%0d results never arrived", awaited_conversions.size());
      error_count++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
